// ----- rtl/bfft_pkg.sv -----
// Shared types, codes and sizes for the best-fit free block table.
package bfft_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = 16;
    localparam int SIZE_W      = 16;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_cmd;

    // flags a cell hands to its right neighbor
    typedef struct packed {
        logic take;  // insert position is at or left of this cell
        logic hit;   // some cell up to here covers the search request
        logic gone;  // remove match at or left of this cell
    } t_flags;

endpackage

// ----- rtl/bfft_cell.sv -----
// One table slot: holds an entry and shifts it left or right on remove and insert.
module bfft_cell
    import bfft_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_left,
    input  t_entry i_right,
    input  t_flags i_lflags,
    output t_entry o_entry,
    output t_flags o_flags,
    output logic   o_first
);

    logic              r_used;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;

    logic n_used;
    logic [ADDR_W-1:0] n_addr;
    logic [SIZE_W-1:0] n_size;

    logic take, hit, match;

    assign take  = !(r_used && (r_size <= i_cmd.size));
    assign hit   = r_used && (r_size >= i_cmd.size);
    assign match = r_used && (r_addr == i_cmd.addr);

    assign o_flags.take = take;
    assign o_flags.hit  = hit || i_lflags.hit;
    assign o_flags.gone = match || i_lflags.gone;
    assign o_first      = hit && !i_lflags.hit;

    assign o_entry.used = r_used;
    assign o_entry.addr = r_addr;
    assign o_entry.size = r_size;

    always_comb begin
        n_used = r_used;
        n_addr = r_addr;
        n_size = r_size;
        if (i_cmd.en && (i_cmd.op == OP_INSERT) && take) begin
            if (i_lflags.take) begin
                n_used = i_left.used;
                n_addr = i_left.addr;
                n_size = i_left.size;
            end else begin
                n_used = 1'b1;
                n_addr = i_cmd.addr;
                n_size = i_cmd.size;
            end
        end else if (i_cmd.en && (i_cmd.op == OP_REMOVE) && o_flags.gone) begin
            n_used = i_right.used;
            n_addr = i_right.addr;
            n_size = i_right.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_size <= n_size;
    end

endmodule

// ----- rtl/bfft_chain.sv -----
// Row of table cells plus the best-fit select over their first-hit flags.
module bfft_chain
    import bfft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output logic              o_full,
    output logic              o_hit,
    output logic              o_gone,
    output logic [ADDR_W-1:0] o_found_addr,
    output logic [SIZE_W-1:0] o_found_size
);

    t_entry                 entries [TABLE_DEPTH];
    t_flags                 flags   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] first;

    localparam t_entry EMPTY = '{used: 1'b0, addr: '0, size: '0};
    localparam t_flags NOFLAGS = '{take: 1'b0, hit: 1'b0, gone: 1'b0};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry left, right;
        t_flags lflags;
        if (g == 0) begin : g_head
            assign left   = EMPTY;
            assign lflags = NOFLAGS;
        end else begin : g_mid
            assign left   = entries[g-1];
            assign lflags = flags[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign right = EMPTY;
        end else begin : g_body
            assign right = entries[g+1];
        end

        bfft_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (i_cmd),
            .i_left   (left),
            .i_right  (right),
            .i_lflags (lflags),
            .o_entry  (entries[g]),
            .o_flags  (flags[g]),
            .o_first  (first[g])
        );
    end

    assign o_full = entries[TABLE_DEPTH-1].used;
    assign o_hit  = flags[TABLE_DEPTH-1].hit;
    assign o_gone = flags[TABLE_DEPTH-1].gone;

    // at most one first-hit flag is set, so an OR tree is the mux
    always_comb begin
        o_found_addr = '0;
        o_found_size = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            o_found_addr = o_found_addr | (entries[k].addr & {ADDR_W{first[k]}});
            o_found_size = o_found_size | (entries[k].size & {SIZE_W{first[k]}});
        end
    end

    for (genvar g = 0; g + 1 < TABLE_DEPTH; g++) begin : g_chk
        // occupied slots stay packed at the low end
        a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            entries[g+1].used |-> entries[g].used)
            else $error("table has a hole");
        // ascending size order among occupied slots
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            entries[g+1].used |-> (entries[g].size <= entries[g+1].size))
            else $error("table out of size order");
    end

    a_one_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first))
        else $error("more than one best-fit candidate");

endmodule

// ----- rtl/best_fit_free_block_table_top.sv -----
// Top level of the best-fit free block table: handshakes and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_stall  | i_operation, i_block_address, i_block_size
//  result  | out       | o_valid / i_stall  | o_status, o_found_address, o_found_size
//
// One transfer per cycle while o_stall is low: every operation finishes in the cycle it is taken,
// with the cell row's compare and shift chains settling within that cycle.
// The result register appears on the cycle after the input transfer.
// Input stalls only while a result sits in the register and i_stall is high.
// Synchronous active-low reset empties the table and the result register.
module best_fit_free_block_table_top
    import bfft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic [SIZE_W-1:0] i_block_size,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [ADDR_W-1:0] o_found_address,
    output logic [SIZE_W-1:0] o_found_size
);

    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;

    logic [ST_W-1:0]   n_status;
    logic [ADDR_W-1:0] n_addr;
    logic [SIZE_W-1:0] n_size;

    logic              accept;
    logic              full, hit, gone;
    logic [ADDR_W-1:0] sel_addr;
    logic [SIZE_W-1:0] sel_size;
    t_cmd              cmd;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign cmd.en   = accept && !((i_operation == OP_INSERT) && full);
    assign cmd.op   = i_operation;
    assign cmd.addr = i_block_address;
    assign cmd.size = i_block_size;

    bfft_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_full       (full),
        .o_hit        (hit),
        .o_gone       (gone),
        .o_found_addr (sel_addr),
        .o_found_size (sel_size)
    );

    always_comb begin
        n_addr = '0;
        n_size = '0;
        unique case (i_operation)
            OP_INSERT: n_status = full ? ST_FULL : ST_DONE;
            OP_SEARCH: begin
                n_status = hit ? ST_DONE : ST_NOT_FOUND;
                if (hit) begin
                    n_addr = sel_addr;
                    n_size = sel_size;
                end
            end
            OP_REMOVE: n_status = gone ? ST_DONE : ST_NOT_FOUND;
            default:   n_status = ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_addr   <= n_addr;
            r_size   <= n_size;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_found_address = r_addr;
    assign o_found_size    = r_size;

endmodule
